// File: rtl/power_of_two_weight_quantizer_unit_defines.svh
`ifndef POWER_OF_TWO_WEIGHT_QUANTIZER_UNIT_DEFINES_SVH
`define POWER_OF_TWO_WEIGHT_QUANTIZER_UNIT_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define PWQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define PWQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pwq_pkg.sv
package pwq_pkg;

  // Fixed formats of the weight and code words.
  localparam int WEIGHT_BITS   = 16;
  localparam int FRACTION_BITS = 12;
  localparam int MAX_CODE_BITS = 16;
  localparam int CODE_W        = MAX_CODE_BITS + 1;
  localparam int EXP_W         = 6;
  localparam int EXP_LOW       = -8;
  localparam int EXP_HIGH      = 31;
  localparam int WEIGHT_MAX    = 2 ** (WEIGHT_BITS - 1) - 1;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_BITS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_RND    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_RND    = 3'd4;

  // Scale exponent rounding codes.
  localparam logic [1:0] ER_FLOOR   = 2'd0;
  localparam logic [1:0] ER_NEAREST = 2'd1;
  localparam logic [1:0] ER_CEIL    = 2'd2;

  // Scaled weight rounding codes.
  localparam logic [1:0] VR_NEAREST = 2'd0;
  localparam logic [1:0] VR_FLOOR   = 2'd1;
  localparam logic [1:0] VR_CEIL    = 2'd2;
  localparam logic [1:0] VR_ZERO    = 2'd3;

  // Register values after reset.
  localparam logic [4:0]  RST_CODE_BITS  = 5'd8;
  localparam logic [15:0] RST_RANGE_LOW  = 16'hF000;
  localparam logic [15:0] RST_RANGE_HIGH = 16'h0FFF;
  localparam logic [1:0]  RST_EXP_RND    = ER_FLOOR;
  localparam logic [1:0]  RST_VAL_RND    = VR_NEAREST;

  // Scale settings shared by the datapath stages.
  typedef struct packed {
    logic [EXP_W-1:0]  exp;
    logic [CODE_W-1:0] cmin;
    logic [CODE_W-1:0] cmax;
    logic              err;
    logic [1:0]        vround;
  } scale_t;

  // Clipped code handed to the dequantize stage.
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } code_t;

endpackage

// File: rtl/power_of_two_weight_quantizer_unit.sv
// Power-of-two weight quantizer. Each Q4.12 weight taken with start is scaled
// by 2^E, rounded, clipped to the code range and scaled back; the code, the
// dequantized weight, E and the range error flag appear on the out_ ports for
// exactly one cycle with out_valid. Each item passes through the input
// register, the rounding and clipping registers and the result register.
// The receiver cannot stall: results must be captured when out_valid is high.
// A new item is taken every cycle (start high, busy low); busy is high during
// reset and in the cycle after it. E is computed from the configuration
// registers in two register stages that run alongside the write port, so an
// item may follow a configuration write in the next cycle. Write configuration
// only while no item is in flight.
`include "power_of_two_weight_quantizer_unit_defines.svh"

module power_of_two_weight_quantizer_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [pwq_pkg::WEIGHT_BITS-1:0] in_weight_in,
  input  logic                                   cfg_wr_en,
  input  logic [pwq_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pwq_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  output logic                                   out_valid,
  output logic signed [pwq_pkg::CODE_W-1:0]      out_quant_code,
  output logic signed [pwq_pkg::WEIGHT_BITS-1:0] out_weight_out,
  output logic signed [pwq_pkg::EXP_W-1:0]       out_scale_exponent,
  output logic                                   out_range_error
);

  logic            busy_r;
  logic            accept;
  pwq_pkg::scale_t scale;
  pwq_pkg::code_t  code;

  // Hold off items for the cycle after reset.
  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Configuration registers and scale exponent.
  pwq_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .scale     (scale)
  );

  // Scale, round and clip.
  pwq_quant u_quant (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .weight   (in_weight_in),
    .scale    (scale),
    .code_out (code)
  );

  // Scale back and drive the result ports.
  pwq_dequant u_dequant (
    .clk                (clk),
    .rst_n              (rst_n),
    .code_in            (code),
    .scale              (scale),
    .out_valid          (out_valid),
    .out_quant_code     (out_quant_code),
    .out_weight_out     (out_weight_out),
    .out_scale_exponent (out_scale_exponent),
    .out_range_error    (out_range_error)
  );

  // Every accepted item yields its result on out_valid.
  `PWQ_ASSERT(a_latency, accept |-> ##4 out_valid, "missing result for accepted item")

endmodule

// File: rtl/pwq_scale.sv
`include "power_of_two_weight_quantizer_unit_defines.svh"

module pwq_scale (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [pwq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pwq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output pwq_pkg::scale_t                    scale
);

  // Normalized limit and bound of one side of the range.
  typedef struct packed {
    logic        active;
    logic        zero;
    logic [4:0]  k0;
    logic [15:0] mn;
    logic [15:0] dn;
  } bound_t;

  // Position of the highest set bit.
  function automatic logic [3:0] msb16(input logic [15:0] v);
    logic [3:0] p;
    p = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) p = 4'(i);
    end
    return p;
  endfunction

  // Build the normalized pair for limit m over bound d.
  function automatic bound_t make_bound(input logic act, input logic [15:0] m,
                                        input logic [15:0] d);
    bound_t b;
    logic [3:0] pm;
    logic [3:0] pd;
    pm       = msb16(m);
    pd       = msb16(d);
    b.active = act;
    b.zero   = (m == 16'd0);
    b.k0     = 5'(pm) - 5'(pd);
    b.mn     = m << (4'd15 - pm);
    b.dn     = d << (4'd15 - pd);
    return b;
  endfunction

  // Rounded log2(m / d) plus the fraction bits.
  function automatic logic signed [6:0] bound_exp(input bound_t b, input logic [1:0] mode);
    logic        lt;
    logic [16:0] a;
    logic [33:0] sq_a;
    logic [33:0] sq_d;
    logic        adj;
    logic [6:0]  k;
    lt   = (b.mn < b.dn);
    a    = lt ? {b.mn, 1'b0} : {1'b0, b.mn};
    sq_a = 34'(a) * 34'(a);
    sq_d = (34'(b.dn) * 34'(b.dn)) << 1;
    k    = {{2{b.k0[4]}}, b.k0};
    unique case (mode)
      pwq_pkg::ER_CEIL:    adj = (b.mn != b.dn);
      pwq_pkg::ER_NEAREST: adj = (sq_a >= sq_d);
      default:             adj = 1'b0;
    endcase
    return $signed(7'(pwq_pkg::FRACTION_BITS) + k - 7'(lt) + 7'(adj));
  endfunction

  logic [4:0]  code_bits_r, code_bits_nxt;
  logic [15:0] range_low_r, range_low_nxt;
  logic [15:0] range_high_r, range_high_nxt;
  logic [1:0]  exp_rnd_r, exp_rnd_nxt;
  logic [1:0]  val_rnd_r, val_rnd_nxt;

  bound_t      lo_r, lo_nxt;
  bound_t      hi_r, hi_nxt;
  logic [16:0] cmin_r, cmin_nxt;
  logic [16:0] cmax_r, cmax_nxt;
  logic        err_r, err_nxt;
  logic [5:0]  exp_r, exp_nxt;

  logic [4:0]  n_eff;
  logic        lo_nonneg;
  logic        hi_nonpos;
  logic [16:0] lim;
  logic [16:0] pow;
  logic [16:0] d_lo;

  // Register writes; reset loads the defaults.
  always_comb begin
    code_bits_nxt  = code_bits_r;
    range_low_nxt  = range_low_r;
    range_high_nxt = range_high_r;
    exp_rnd_nxt    = exp_rnd_r;
    val_rnd_nxt    = val_rnd_r;
    if (!rst_n) begin
      code_bits_nxt  = pwq_pkg::RST_CODE_BITS;
      range_low_nxt  = pwq_pkg::RST_RANGE_LOW;
      range_high_nxt = pwq_pkg::RST_RANGE_HIGH;
      exp_rnd_nxt    = pwq_pkg::RST_EXP_RND;
      val_rnd_nxt    = pwq_pkg::RST_VAL_RND;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pwq_pkg::CFG_CODE_BITS:  code_bits_nxt  = cfg_wdata[4:0];
        pwq_pkg::CFG_RANGE_LOW:  range_low_nxt  = cfg_wdata;
        pwq_pkg::CFG_RANGE_HIGH: range_high_nxt = cfg_wdata;
        pwq_pkg::CFG_EXP_RND:    exp_rnd_nxt    = cfg_wdata[1:0];
        pwq_pkg::CFG_VAL_RND:    val_rnd_nxt    = cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Code range and normalized bounds, taken from the incoming register values
  // so that they are registered alongside a write and feed the exponent stage.
  always_comb begin
    if (code_bits_nxt == 5'd0) begin
      n_eff = 5'd1;
    end else if (code_bits_nxt > 5'(pwq_pkg::MAX_CODE_BITS)) begin
      n_eff = 5'(pwq_pkg::MAX_CODE_BITS);
    end else begin
      n_eff = code_bits_nxt;
    end
    lo_nonneg = !range_low_nxt[15];
    hi_nonpos = range_high_nxt[15] || (range_high_nxt == 16'd0);
    err_nxt   = lo_nonneg && hi_nonpos;
    lim       = (17'd1 << n_eff) - 17'd1;
    pow       = 17'd1 << (n_eff - 5'd1);
    d_lo      = 17'd0 - {range_low_nxt[15], range_low_nxt};
    priority if (lo_nonneg) begin
      cmin_nxt = 17'd0;
      cmax_nxt = lim;
    end else if (hi_nonpos) begin
      cmin_nxt = 17'd0 - lim;
      cmax_nxt = 17'd0;
    end else begin
      cmin_nxt = 17'd0 - pow;
      cmax_nxt = pow - 17'd1;
    end
    lo_nxt = make_bound(!lo_nonneg, hi_nonpos ? lim[15:0] : pow[15:0], d_lo[15:0]);
    hi_nxt = make_bound(!hi_nonpos, cmax_nxt[15:0], range_high_nxt);
  end

  // Least exponent over the active bounds, saturated.
  always_comb begin
    logic signed [6:0] x_lo;
    logic signed [6:0] x_hi;
    logic signed [6:0] e;
    x_lo = bound_exp(lo_r, exp_rnd_r);
    x_hi = hi_r.zero ? 7'(pwq_pkg::EXP_LOW) : bound_exp(hi_r, exp_rnd_r);
    priority if (lo_r.active && hi_r.active) begin
      e = (x_lo < x_hi) ? x_lo : x_hi;
    end else if (lo_r.active) begin
      e = x_lo;
    end else begin
      e = x_hi;
    end
    if (e < 7'(pwq_pkg::EXP_LOW)) e = 7'(pwq_pkg::EXP_LOW);
    if (e > 7'(pwq_pkg::EXP_HIGH)) e = 7'(pwq_pkg::EXP_HIGH);
    exp_nxt = 6'(e);
  end

  // Configuration registers and the two exponent stages.
  always_ff @(posedge clk) begin
    code_bits_r  <= code_bits_nxt;
    range_low_r  <= range_low_nxt;
    range_high_r <= range_high_nxt;
    exp_rnd_r    <= exp_rnd_nxt;
    val_rnd_r    <= val_rnd_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    cmin_r       <= cmin_nxt;
    cmax_r       <= cmax_nxt;
    err_r        <= err_nxt;
    exp_r        <= exp_nxt;
  end

  assign scale.exp    = exp_r;
  assign scale.cmin   = cmin_r;
  assign scale.cmax   = cmax_r;
  assign scale.err    = err_r;
  assign scale.vround = val_rnd_r;

  // An empty range must leave both bounds unused.
  `PWQ_ASSERT(a_err_no_bound, err_r |-> (!lo_r.active && !hi_r.active), "range error with a bound")
  // The exponent stays at or above its saturation floor once loaded.
  `PWQ_ASSERT(a_exp_range, $past(rst_n) |-> ($signed(exp_r) >= -6'sd8), "exponent below floor")

endmodule

// File: rtl/pwq_quant.sv
`include "power_of_two_weight_quantizer_unit_defines.svh"

module pwq_quant (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic signed [pwq_pkg::WEIGHT_BITS-1:0] weight,
  input  pwq_pkg::scale_t                     scale,
  output pwq_pkg::code_t                      code_out
);

  logic        in_vld_r;
  logic [15:0] w_r;
  logic        q_vld_r;
  logic [35:0] val_r, val_nxt;
  logic        c_vld_r;
  logic [16:0] code_r, code_nxt;
  logic        code_ok;

  // Scale the weight by the power of two and round it.
  always_comb begin
    logic        neg;
    logic [15:0] mag;
    logic [31:0] mag32;
    logic [4:0]  sh;
    logic [15:0] down;
    logic        rest;
    logic        half;
    logic        inc;
    logic [34:0] mag_s;
    neg   = w_r[15];
    mag   = neg ? (16'd0 - w_r) : w_r;
    mag32 = {16'd0, mag};
    sh    = 5'(6'd12 - scale.exp);
    down  = 16'(mag32 >> sh);
    rest  = (mag32 & ((32'd1 << sh) - 32'd1)) != 32'd0;
    half  = mag32[sh - 5'd1];
    unique case (scale.vround)
      pwq_pkg::VR_NEAREST: inc = half;
      pwq_pkg::VR_FLOOR:   inc = neg && rest;
      pwq_pkg::VR_CEIL:    inc = !neg && rest;
      pwq_pkg::VR_ZERO:    inc = 1'b0;
    endcase
    if ($signed(scale.exp) >= 6'sd12) begin
      mag_s = 35'(mag) << 5'(scale.exp - 6'd12);
    end else begin
      mag_s = 35'(down) + 35'(inc);
    end
    val_nxt = neg ? (36'd0 - {1'b0, mag_s}) : {1'b0, mag_s};
  end

  // Clip to the code range.
  always_comb begin
    logic [35:0] cmin36;
    logic [35:0] cmax36;
    cmin36 = {{19{scale.cmin[16]}}, scale.cmin};
    cmax36 = {{19{scale.cmax[16]}}, scale.cmax};
    priority if ($signed(val_r) < $signed(cmin36)) begin
      code_nxt = scale.cmin;
    end else if ($signed(val_r) > $signed(cmax36)) begin
      code_nxt = scale.cmax;
    end else begin
      code_nxt = val_r[16:0];
    end
  end

  // Item valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      q_vld_r  <= 1'b0;
      c_vld_r  <= 1'b0;
    end else begin
      in_vld_r <= accept;
      q_vld_r  <= in_vld_r;
      c_vld_r  <= q_vld_r;
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (accept) w_r <= weight;
    val_r  <= val_nxt;
    code_r <= code_nxt;
  end

  assign code_out.valid = c_vld_r;
  assign code_out.code  = code_r;

  // The held code lies inside the configured range.
  assign code_ok = ($signed(code_r) >= $signed(scale.cmin)) &&
                   ($signed(code_r) <= $signed(scale.cmax));

  // A clipped code never leaves the configured range.
  `PWQ_ASSERT(a_code_in_range, c_vld_r |-> code_ok, "code outside range")

endmodule

// File: rtl/pwq_dequant.sv
`include "power_of_two_weight_quantizer_unit_defines.svh"

module pwq_dequant (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pwq_pkg::code_t                         code_in,
  input  pwq_pkg::scale_t                        scale,
  output logic                                   out_valid,
  output logic signed [pwq_pkg::CODE_W-1:0]      out_quant_code,
  output logic signed [pwq_pkg::WEIGHT_BITS-1:0] out_weight_out,
  output logic signed [pwq_pkg::EXP_W-1:0]       out_scale_exponent,
  output logic                                   out_range_error
);

  logic        valid_r;
  logic [16:0] code_r, code_nxt;
  logic [15:0] wout_r, wout_nxt;
  logic [5:0]  exp_r, exp_nxt;
  logic        err_r;

  // Scale the code back to Q4.12, round to nearest and saturate; a range error clears code, weight and exponent.
  always_comb begin
    logic        neg;
    logic [16:0] mag;
    logic [31:0] mag32;
    logic [4:0]  sh;
    logic [36:0] md;
    neg   = code_in.code[16];
    mag   = neg ? (17'd0 - code_in.code) : code_in.code;
    mag32 = {15'd0, mag};
    sh    = 5'(scale.exp - 6'd12);
    if ($signed(scale.exp) <= 6'sd12) begin
      md = 37'(mag) << 5'(6'd12 - scale.exp);
    end else begin
      md = 37'(mag32 >> sh) + 37'(mag32[sh - 5'd1]);
    end
    if (neg) begin
      wout_nxt = (md > 37'(pwq_pkg::WEIGHT_MAX + 1)) ? 16'h8000 : 16'(37'd0 - md);
    end else begin
      wout_nxt = (md > 37'(pwq_pkg::WEIGHT_MAX)) ? 16'(pwq_pkg::WEIGHT_MAX) : md[15:0];
    end
    code_nxt = code_in.code;
    exp_nxt  = scale.exp;
    if (scale.err) begin
      wout_nxt = 16'd0;
      code_nxt = 17'd0;
      exp_nxt  = 6'd0;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= code_in.valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    wout_r <= wout_nxt;
    exp_r  <= exp_nxt;
    err_r  <= scale.err;
  end

  assign out_valid          = valid_r;
  assign out_quant_code     = $signed(code_r);
  assign out_weight_out     = $signed(wout_r);
  assign out_scale_exponent = $signed(exp_r);
  assign out_range_error    = err_r;

  // A negative weight can only come from a negative code.
  `PWQ_ASSERT(a_sign_match, (valid_r && wout_r[15]) |-> code_r[16], "weight sign without code sign")
  // Reset empties the result stage.
  `PWQ_ASSERT_RST(a_reset_clears, !rst_n |=> !valid_r, "result strobe after reset")

endmodule
